>>> hdl/lr1sr_pkg.sv
// shared types and constants of the lr(1) shift-reduce recognizer
// command and status structs between controller and datapath, item codes
// no dependencies
package lr1sr_pkg;

	// default sizes of the tables and the stack
	localparam int DEF_STATE_COUNT    = 1024;
	localparam int DEF_SYMBOL_COUNT   = 256;
	localparam int DEF_RULE_COUNT     = 256;
	localparam int DEF_STACK_DEPTH    = 256;
	localparam int DEF_MAX_RHS_LENGTH = 15;

	// field widths
	localparam int STATE_W  = 10;
	localparam int SYMBOL_W = 8;
	localparam int KIND_W   = 2;
	localparam int RULE_W   = 8;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int LEVEL_W  = 9;
	localparam int RED_W    = 8;
	localparam int ENTRY_W  = KIND_W + STATE_W;
	localparam int RENTRY_W = SYMBOL_W + LEN_W;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 24;

	// item actions
	localparam logic [1:0] ACT_LOAD_ENTRY = 2'd0;
	localparam logic [1:0] ACT_LOAD_RULE  = 2'd1;
	localparam logic [1:0] ACT_START      = 2'd2;
	localparam logic [1:0] ACT_TOKEN      = 2'd3;

	// action table entry kinds
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FAULT  = 2'd3;

	typedef struct packed {
		logic                capture;
		logic                clr_step;
		logic                tbl_wr;
		logic                rule_wr;
		logic                start;
		logic                rd_tok;
		logic                rd_lhs;
		logic                push;
		logic                cnt_inc;
		logic                rule_rd;
		logic                pop;
		logic                top_ld;
		logic                err_set;
		logic                out_ld;
		logic [STATUS_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic                clr_done;
		logic [1:0]          act;
		logic                last;
		logic [STATUS_W-1:0] err;
		logic [KIND_W-1:0]   kind;
		logic                val_bad;
		logic                cnt_lim;
		logic                full;
		logic                under;
		logic                out_free;
	} sts_t;

endpackage

>>> hdl/lr1sr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lr1sr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lr1sr_ctrl.sv
// sequencer of the recognizer: clearing pass, item dispatch, shift/reduce loop
// uses lr1sr_pkg for the command and status structs and codes
module lr1sr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lr1sr_pkg::sts_t   sts,
	output lr1sr_pkg::cmd_t   cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISPATCH = 4'd2;
	localparam logic [3:0] S_LOOK     = 4'd3;
	localparam logic [3:0] S_EVAL     = 4'd4;
	localparam logic [3:0] S_RULE     = 4'd5;
	localparam logic [3:0] S_STK      = 4'd6;
	localparam logic [3:0] S_GLOOK    = 4'd7;
	localparam logic [3:0] S_GEVAL    = 4'd8;
	localparam logic [3:0] S_RESP     = 4'd9;

	logic [3:0]                     state_q, state_n;
	logic [lr1sr_pkg::STATUS_W-1:0] res_q, res_n;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		res_n   = res_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_n     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				res_n   = lr1sr_pkg::ST_OK;
				state_n = S_RESP;
				unique case (sts.act)
					lr1sr_pkg::ACT_LOAD_ENTRY: cmd.tbl_wr = 1'b1;
					lr1sr_pkg::ACT_LOAD_RULE:  cmd.rule_wr = 1'b1;
					lr1sr_pkg::ACT_START:      cmd.start = 1'b1;
					default: begin
						// latched error answers without parsing
						if (sts.err != lr1sr_pkg::ST_OK) begin
							res_n = sts.err;
						end else begin
							state_n = S_LOOK;
						end
					end
				endcase
			end
			S_LOOK: begin
				cmd.rd_tok = 1'b1;
				state_n    = S_EVAL;
			end
			S_EVAL: begin
				state_n = S_RESP;
				if (sts.kind == lr1sr_pkg::KIND_SHIFT) begin
					if (sts.full) begin
						cmd.err_set = 1'b1;
						cmd.code    = lr1sr_pkg::ST_FAULT;
						res_n       = lr1sr_pkg::ST_FAULT;
					end else begin
						cmd.push = 1'b1;
						res_n    = sts.last ? lr1sr_pkg::ST_ACCEPT : lr1sr_pkg::ST_OK;
					end
				end else if (sts.kind == lr1sr_pkg::KIND_REDUCE && !sts.val_bad) begin
					cmd.cnt_inc = 1'b1;
					if (sts.cnt_lim) begin
						// runaway reduction chain
						cmd.err_set = 1'b1;
						cmd.code    = lr1sr_pkg::ST_SYNTAX;
						res_n       = lr1sr_pkg::ST_SYNTAX;
					end else begin
						cmd.rule_rd = 1'b1;
						state_n     = S_RULE;
					end
				end else begin
					cmd.err_set = 1'b1;
					cmd.code    = lr1sr_pkg::ST_SYNTAX;
					res_n       = lr1sr_pkg::ST_SYNTAX;
				end
			end
			S_RULE: begin
				if (sts.under) begin
					cmd.err_set = 1'b1;
					cmd.code    = lr1sr_pkg::ST_FAULT;
					res_n       = lr1sr_pkg::ST_FAULT;
					state_n     = S_RESP;
				end else begin
					cmd.pop = 1'b1;
					state_n = S_STK;
				end
			end
			S_STK: begin
				cmd.top_ld = 1'b1;
				state_n    = S_GLOOK;
			end
			S_GLOOK: begin
				cmd.rd_lhs = 1'b1;
				state_n    = S_GEVAL;
			end
			S_GEVAL: begin
				if (sts.kind != lr1sr_pkg::KIND_SHIFT) begin
					cmd.err_set = 1'b1;
					cmd.code    = lr1sr_pkg::ST_SYNTAX;
					res_n       = lr1sr_pkg::ST_SYNTAX;
					state_n     = S_RESP;
				end else if (sts.full) begin
					cmd.err_set = 1'b1;
					cmd.code    = lr1sr_pkg::ST_FAULT;
					res_n       = lr1sr_pkg::ST_FAULT;
					state_n     = S_RESP;
				end else begin
					// goto pushed, look the same token up again
					cmd.push = 1'b1;
					state_n  = S_LOOK;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.code   = res_q;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= lr1sr_pkg::ST_OK;
		end else begin
			state_q <= state_n;
			res_q   <= res_n;
		end
	end

endmodule

>>> hdl/lr1sr_dp.sv
// datapath of the recognizer: input registers, action/rule/stack memories,
// stack pointer, reduction counter, error latch and output register
// uses lr1sr_pkg and lr1sr_ram
module lr1sr_dp #(
	parameter int STATE_COUNT    = lr1sr_pkg::DEF_STATE_COUNT,
	parameter int SYMBOL_COUNT   = lr1sr_pkg::DEF_SYMBOL_COUNT,
	parameter int RULE_COUNT     = lr1sr_pkg::DEF_RULE_COUNT,
	parameter int STACK_DEPTH    = lr1sr_pkg::DEF_STACK_DEPTH,
	parameter int MAX_RHS_LENGTH = lr1sr_pkg::DEF_MAX_RHS_LENGTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lr1sr_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lr1sr_pkg::OUT_DATA_W-1:0] m_tdata,
	input  lr1sr_pkg::cmd_t                  cmd,
	output lr1sr_pkg::sts_t                  sts
);

	localparam int TBL_DEPTH    = STATE_COUNT * SYMBOL_COUNT;
	localparam int TAW          = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int RAW          = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
	localparam int SAW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW          = $clog2(STACK_DEPTH + 1);
	localparam int REDUCE_LIMIT = 16 * STACK_DEPTH;
	localparam int CW           = $clog2(REDUCE_LIMIT + 2);

	localparam int SW  = lr1sr_pkg::STATE_W;
	localparam int YW  = lr1sr_pkg::SYMBOL_W;
	localparam int KW  = lr1sr_pkg::KIND_W;
	localparam int LW  = lr1sr_pkg::LEN_W;

	// captured item
	logic [1:0]                   act_q;
	logic [SW-1:0]                tstate_q;
	logic [YW-1:0]                tsym_q;
	logic [KW-1:0]                tkind_q;
	logic [SW-1:0]                tval_q;
	logic [lr1sr_pkg::RULE_W-1:0] rnum_q;
	logic [YW-1:0]                rlhs_q;
	logic [LW-1:0]                rlen_q;
	logic [YW-1:0]                tok_q;
	logic                         last_q;

	// parse state
	logic [SPW-1:0]                 sp_q;
	logic [SW-1:0]                  top_q;
	logic [CW-1:0]                  cnt_q;
	logic [lr1sr_pkg::STATUS_W-1:0] err_q;
	logic [TAW-1:0]                 clr_q;
	logic                           rng_q;
	logic [YW-1:0]                  lhs_q;

	// output register
	logic                           out_valid_q;
	logic [lr1sr_pkg::STATUS_W-1:0] out_status_q;
	logic [lr1sr_pkg::LEVEL_W-1:0]  out_level_q;
	logic [lr1sr_pkg::RED_W-1:0]    out_red_q;

	// memory ports
	logic                          act_we, act_re;
	logic [TAW-1:0]                act_waddr, act_raddr, tbl_addr;
	logic [lr1sr_pkg::ENTRY_W-1:0] act_wdata, act_rdata;
	logic                          rule_we;
	logic [RAW-1:0]                rule_waddr, rule_raddr;
	logic [lr1sr_pkg::RENTRY_W-1:0] rule_wdata, rule_rdata;
	logic                          stk_we, stk_re;
	logic [SAW-1:0]                stk_waddr, stk_raddr;
	logic [SW-1:0]                 stk_wdata, stk_rdata;

	logic          tbl_ok, rule_ok, rd_rng;
	logic [KW-1:0] kind_w;
	logic [SW-1:0] val_w, val_rd;
	logic [YW-1:0] rd_sym, r_lhs;
	logic [LW-1:0] len_w, r_len;
	logic          out_free;

	// ---- action table
	assign tbl_ok   = (32'(tstate_q) < STATE_COUNT) && (32'(tsym_q) < SYMBOL_COUNT);
	assign tbl_addr = TAW'(tstate_q) * TAW'(SYMBOL_COUNT) + TAW'(tsym_q);
	assign kind_w   = (tkind_q == lr1sr_pkg::KIND_SHIFT || tkind_q == lr1sr_pkg::KIND_REDUCE)
		? tkind_q : lr1sr_pkg::KIND_NONE;
	assign val_w    = (kind_w == lr1sr_pkg::KIND_NONE) ? '0 : tval_q;

	assign act_we    = cmd.clr_step | (cmd.tbl_wr & tbl_ok);
	assign act_waddr = cmd.clr_step ? clr_q : tbl_addr;
	assign act_wdata = cmd.clr_step ? '0 : {kind_w, val_w};

	assign act_re    = cmd.rd_tok | cmd.rd_lhs;
	assign rd_sym    = cmd.rd_lhs ? lhs_q : tok_q;
	assign rd_rng    = (32'(top_q) < STATE_COUNT) && (32'(rd_sym) < SYMBOL_COUNT);
	assign act_raddr = TAW'(top_q) * TAW'(SYMBOL_COUNT) + TAW'(rd_sym);
	assign val_rd    = act_rdata[SW-1:0];

	lr1sr_ram #(.WIDTH(lr1sr_pkg::ENTRY_W), .DEPTH(TBL_DEPTH)) u_act_ram (
		.clk  (clk),
		.we   (act_we),
		.waddr(act_waddr),
		.wdata(act_wdata),
		.re   (act_re),
		.raddr(act_raddr),
		.rdata(act_rdata)
	);

	// ---- rule table
	assign rule_ok    = 32'(rnum_q) < RULE_COUNT;
	assign len_w      = (32'(rlen_q) > MAX_RHS_LENGTH) ? LW'(MAX_RHS_LENGTH) : rlen_q;
	assign rule_we    = cmd.rule_wr & rule_ok;
	assign rule_waddr = RAW'(rnum_q);
	assign rule_wdata = {rlhs_q, len_w};
	assign rule_raddr = RAW'(val_rd);
	assign r_len      = rule_rdata[LW-1:0];
	assign r_lhs      = rule_rdata[lr1sr_pkg::RENTRY_W-1:LW];

	lr1sr_ram #(.WIDTH(lr1sr_pkg::RENTRY_W), .DEPTH(RULE_COUNT)) u_rule_ram (
		.clk  (clk),
		.we   (rule_we),
		.waddr(rule_waddr),
		.wdata(rule_wdata),
		.re   (cmd.rule_rd),
		.raddr(rule_raddr),
		.rdata(rule_rdata)
	);

	// ---- state stack, bottom entry written with state zero on clear and start
	assign stk_we    = cmd.push | cmd.start | cmd.clr_step;
	assign stk_waddr = cmd.push ? SAW'(sp_q) : '0;
	assign stk_wdata = cmd.push ? val_rd : '0;
	assign stk_re    = cmd.pop;
	assign stk_raddr = SAW'(sp_q - SPW'(r_len) - SPW'(1));

	lr1sr_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stk_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	// ---- item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= s_tuser;
			tstate_q <= s_tdata[9:0];
			tsym_q   <= s_tdata[17:10];
			tkind_q  <= s_tdata[19:18];
			tval_q   <= s_tdata[29:20];
			rnum_q   <= s_tdata[37:30];
			rlhs_q   <= s_tdata[45:38];
			rlen_q   <= s_tdata[49:46];
			tok_q    <= s_tdata[57:50];
			last_q   <= s_tlast;
		end
		if (act_re) begin
			rng_q <= rd_rng;
		end
		if (cmd.pop) begin
			lhs_q <= r_lhs;
		end
		if (cmd.out_ld) begin
			out_status_q <= cmd.code;
			out_level_q  <= lr1sr_pkg::LEVEL_W'(sp_q);
			out_red_q    <= (32'(cnt_q) > 255) ? 8'd255 : lr1sr_pkg::RED_W'(cnt_q);
		end
	end

	// ---- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= SPW'(1);
			top_q       <= '0;
			cnt_q       <= '0;
			err_q       <= lr1sr_pkg::ST_OK;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + TAW'(1);
			end
			if (cmd.start) begin
				sp_q  <= SPW'(1);
				top_q <= '0;
			end else if (cmd.push) begin
				sp_q  <= sp_q + SPW'(1);
				top_q <= val_rd;
			end else if (cmd.pop) begin
				sp_q <= sp_q - SPW'(r_len);
			end else if (cmd.top_ld) begin
				top_q <= stk_rdata;
			end
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.start) begin
				err_q <= lr1sr_pkg::ST_OK;
			end else if (cmd.err_set) begin
				err_q <= cmd.code;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_red_q, out_level_q, out_status_q};

	assign sts.clr_done = (clr_q == TAW'(TBL_DEPTH - 1));
	assign sts.act      = act_q;
	assign sts.last     = last_q;
	assign sts.err      = err_q;
	assign sts.kind     = rng_q ? act_rdata[lr1sr_pkg::ENTRY_W-1:SW] : lr1sr_pkg::KIND_NONE;
	assign sts.val_bad  = 32'(val_rd) >= RULE_COUNT;
	assign sts.cnt_lim  = cnt_q >= CW'(REDUCE_LIMIT);
	assign sts.full     = sp_q >= SPW'(STACK_DEPTH);
	assign sts.under    = 32'(r_len) >= 32'(sp_q);
	assign sts.out_free = out_free;

	// stack level always within one and the depth
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q != '0) && (32'(sp_q) <= STACK_DEPTH))
		else $error("stack pointer out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (sp_q < SPW'(STACK_DEPTH)))
		else $error("push onto a full stack");

	// a pop never takes the bottom state and lowers the level by the rule length
	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (sp_q != '0) && (sp_q == $past(sp_q) - SPW'($past(r_len))))
		else $error("pop left wrong level");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || m_tready))
		else $error("result overwrote a pending transfer");

	a_rule_known: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rule_rd |-> (32'(val_rd) < RULE_COUNT) && (act_rdata[11:10] == lr1sr_pkg::KIND_REDUCE))
		else $error("rule read for a non-reduce entry");

endmodule

>>> hdl/lr1_shift_reduce_recognizer.sv
// lr(1) shift-reduce recognizer: load, start and token items in, one result per item out
// a load or start item goes from dispatch to its result; a token goes through lookup and evaluation
// (one action-table read per shift, rule read, stack read and goto read per reduction)
// one item at a time, next item accepted once its result is registered; a busy output stalls the result
// reset: async active low; then a clearing pass over all STATE_COUNT*SYMBOL_COUNT entries
// (262144 at defaults) empties the action table, s_tready stays low meanwhile
module lr1_shift_reduce_recognizer #(
	parameter int STATE_COUNT    = lr1sr_pkg::DEF_STATE_COUNT,
	parameter int SYMBOL_COUNT   = lr1sr_pkg::DEF_SYMBOL_COUNT,
	parameter int RULE_COUNT     = lr1sr_pkg::DEF_RULE_COUNT,
	parameter int STACK_DEPTH    = lr1sr_pkg::DEF_STACK_DEPTH,
	parameter int MAX_RHS_LENGTH = lr1sr_pkg::DEF_MAX_RHS_LENGTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// table_state[9:0] table_symbol[17:10] entry_kind[19:18] entry_value[29:20]
	// rule_number[37:30] rule_lhs[45:38] rule_length[49:46] token_symbol[57:50]
	input  logic [lr1sr_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]                       s_tuser,
	// last_token
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[1:0] stack_level[10:2] reductions_done[18:11]
	output logic [lr1sr_pkg::OUT_DATA_W-1:0] m_tdata
);

	lr1sr_pkg::cmd_t cmd;
	lr1sr_pkg::sts_t sts;

	lr1sr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lr1sr_dp #(
		.STATE_COUNT   (STATE_COUNT),
		.SYMBOL_COUNT  (SYMBOL_COUNT),
		.RULE_COUNT    (RULE_COUNT),
		.STACK_DEPTH   (STACK_DEPTH),
		.MAX_RHS_LENGTH(MAX_RHS_LENGTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

>>> tb/sv/lr1_checker.sv
`timescale 1ns / 1ps
// result checker of the lr(1) shift-reduce recognizer: watches both stream channels,
// predicts every result from its own tables and state stack and compares them in order
// depends on lr1sr_pkg
module lr1_checker
	import lr1sr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    pending,
	output int                    checked
);

	localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
	localparam int RULE_COUNT   = DEF_RULE_COUNT;
	localparam int REDUCE_LIMIT = 16 * STACK_DEPTH;

	// status sits in the lowest bits of m_tdata
	typedef struct packed {
		logic [RED_W-1:0]    reductions;
		logic [LEVEL_W-1:0]  level;
		logic [STATUS_W-1:0] status;
	} parse_result_t;

	logic [ENTRY_W-1:0]  action_mem [int];
	logic [RENTRY_W-1:0] rule_mem [RULE_COUNT];
	logic [STATE_W-1:0]  parse_stack [STACK_DEPTH];
	int unsigned         depth;
	logic [STATUS_W-1:0] error_code;
	parse_result_t       awaited_results [$];

	// entries never loaded read as kind none
	function automatic logic [ENTRY_W-1:0] entry_at(input logic [STATE_W-1:0] st,
			input logic [SYMBOL_W-1:0] sym);
		int key;
		key = int'({st, sym});
		if (action_mem.exists(key))
			return action_mem[key];
		return '0;
	endfunction

	function automatic bit push_state(input logic [STATE_W-1:0] st);
		if (depth >= STACK_DEPTH)
			return 1'b0;
		parse_stack[depth] = st;
		depth++;
		return 1'b1;
	endfunction

	function automatic logic [STATUS_W-1:0] shift_reduce(input logic [SYMBOL_W-1:0] sym,
			output int unsigned nred);
		logic [ENTRY_W-1:0]  ent;
		logic [ENTRY_W-1:0]  jump;
		logic [RENTRY_W-1:0] rule;
		nred = 0;
		while (1'b1) begin
			ent = entry_at(parse_stack[depth-1], sym);
			if (ent[ENTRY_W-1 -: KIND_W] == KIND_SHIFT)
				return push_state(ent[STATE_W-1:0]) ? ST_OK : ST_FAULT;
			if (ent[ENTRY_W-1 -: KIND_W] != KIND_REDUCE || ent[STATE_W-1:0] >= RULE_COUNT)
				return ST_SYNTAX;
			nred++;
			if (nred > REDUCE_LIMIT)
				return ST_SYNTAX;
			rule = rule_mem[ent[RULE_W-1:0]];
			// the pop may not empty the stack
			if (rule[LEN_W-1:0] >= depth)
				return ST_FAULT;
			depth -= rule[LEN_W-1:0];
			jump = entry_at(parse_stack[depth-1], rule[RENTRY_W-1 -: SYMBOL_W]);
			if (jump[ENTRY_W-1 -: KIND_W] != KIND_SHIFT)
				return ST_SYNTAX;
			if (!push_state(jump[STATE_W-1:0]))
				return ST_FAULT;
		end
		return ST_SYNTAX;
	endfunction

	// s_tdata: state[9:0] symbol[17:10] kind[19:18] value[29:20]
	// rule[37:30] lhs[45:38] length[49:46] token[57:50]
	function automatic parse_result_t recognize_item(input logic [1:0] act,
			input logic [IN_DATA_W-1:0] d, input logic last);
		parse_result_t       res;
		logic [KIND_W-1:0]   kind;
		logic [STATE_W-1:0]  val;
		logic [STATUS_W-1:0] st;
		int unsigned         nred;
		nred = 0;
		st = ST_OK;
		case (act)
			ACT_LOAD_ENTRY: begin
				kind = d[19:18];
				val = d[29:20];
				// the unused kind is stored as none, and none keeps no value
				if (kind != KIND_SHIFT && kind != KIND_REDUCE) begin
					kind = KIND_NONE;
					val = '0;
				end
				action_mem[int'({d[9:0], d[17:10]})] = {kind, val};
			end
			ACT_LOAD_RULE: begin
				rule_mem[d[37:30]] = {d[45:38], d[49:46]};
			end
			ACT_START: begin
				parse_stack[0] = '0;
				depth = 1;
				error_code = ST_OK;
			end
			default: begin
				if (error_code != ST_OK) begin
					st = error_code;
				end else begin
					st = shift_reduce(d[57:50], nred);
					if (st != ST_OK)
						error_code = st;
					else if (last)
						st = ST_ACCEPT;
				end
			end
		endcase
		res.status = st;
		res.level = depth[LEVEL_W-1:0];
		res.reductions = (nred > 255) ? 8'd255 : nred[RED_W-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		parse_result_t want;
		parse_result_t got;
		int            errs;
		errs = 0;
		if (!arst_n) begin
			// reset empties the action table and leaves state zero alone on the stack
			action_mem.delete();
			awaited_results.delete();
			parse_stack[0] = '0;
			depth = 1;
			error_code = ST_OK;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = parse_result_t'(m_tdata[$bits(parse_result_t)-1:0]);
				checked <= checked + 1;
				if (awaited_results.size() == 0) begin
					$error("result transfer with nothing expected: status %0d", got.status);
					errs++;
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						errs++;
					end
					if (got.level !== want.level) begin
						$error("stack_level: expected %0d, actual %0d", want.level, got.level);
						errs++;
					end
					if (got.reductions !== want.reductions) begin
						$error("reductions_done: expected %0d, actual %0d",
							want.reductions, got.reductions);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited_results.insert(awaited_results.size(),
					recognize_item(s_tuser, s_tdata, s_tlast));
			fail_count <= fail_count + errs;
			pending <= awaited_results.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// top of the lr(1) recognizer testbench: clock, reset, directed and random grammar stimulus
// with random idling on both channels, and the verdict
// depends on lr1sr_pkg, lr1_shift_reduce_recognizer and lr1_checker
module testbench;
	import lr1sr_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam longint TIMEOUT_NS = 1_000_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fail_count;
	int                    pending;
	int                    checked;

	bit idle_on;
	bit rule_loaded [DEF_RULE_COUNT];
	int n_entries;
	int n_rules;
	int n_starts;
	int n_tokens;

	lr1_shift_reduce_recognizer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	lr1_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver stalls in bursts while idling is on
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// unused fields carry random bits, padding above the token stays zero
	function automatic logic [IN_DATA_W-1:0] random_payload();
		logic [IN_DATA_W-1:0] p;
		p = {$urandom, $urandom};
		p[IN_DATA_W-1:58] = '0;
		return p;
	endfunction

	// valid stays high from one item to the next unless a gap is taken
	task automatic send_item(input logic [1:0] act, input logic [IN_DATA_W-1:0] data,
			input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= data;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_rule(input logic [RULE_W-1:0] num, input logic [SYMBOL_W-1:0] lhs,
			input logic [LEN_W-1:0] len);
		logic [IN_DATA_W-1:0] p;
		p = random_payload();
		p[37:30] = num;
		p[45:38] = lhs;
		p[49:46] = len;
		rule_loaded[num] = 1'b1;
		send_item(ACT_LOAD_RULE, p, 1'($urandom));
		n_rules++;
	endtask

	task automatic send_entry(input logic [STATE_W-1:0] st, input logic [SYMBOL_W-1:0] sym,
			input logic [KIND_W-1:0] kind, input logic [STATE_W-1:0] val);
		logic [IN_DATA_W-1:0] p;
		// a reduce must never reach a rule that was not loaded
		if (kind == KIND_REDUCE && val < DEF_RULE_COUNT && !rule_loaded[val[RULE_W-1:0]])
			send_rule(val[RULE_W-1:0], 8'($urandom), 4'($urandom_range(0, 3)));
		p = random_payload();
		p[9:0] = st;
		p[17:10] = sym;
		p[19:18] = kind;
		p[29:20] = val;
		send_item(ACT_LOAD_ENTRY, p, 1'($urandom));
		n_entries++;
	endtask

	task automatic send_start();
		send_item(ACT_START, random_payload(), 1'($urandom));
		n_starts++;
	endtask

	task automatic send_token(input logic [SYMBOL_W-1:0] sym, input logic last);
		logic [IN_DATA_W-1:0] p;
		p = random_payload();
		p[57:50] = sym;
		send_item(ACT_TOKEN, p, last);
		n_tokens++;
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_entry(10'($urandom), 8'($urandom), 2'($urandom), 10'($urandom));
			1: send_rule(8'($urandom), 8'($urandom), 4'($urandom));
			2: send_start();
			default: send_token(8'($urandom), 1'($urandom));
		endcase
	endtask

	// hold the sender until every expected result has been seen
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// small random grammar over a handful of states and symbols, then parses of it
	task automatic grammar_phase();
		logic [STATE_W-1:0]  states [6];
		logic [SYMBOL_W-1:0] terms [4];
		logic [SYMBOL_W-1:0] nonterms [2];
		logic [RULE_W-1:0]   rules [4];
		logic [SYMBOL_W-1:0] lhs;
		logic [SYMBOL_W-1:0] sym;
		int                  r;
		int                  len;
		states[0] = '0;
		for (int i = 1; i < 6; i++)
			states[i] = 10'($urandom);
		for (int i = 0; i < 4; i++)
			terms[i] = 8'($urandom);
		for (int i = 0; i < 2; i++)
			nonterms[i] = 8'($urandom);
		for (int i = 0; i < 4; i++) begin
			rules[i] = 8'($urandom);
			lhs = ($urandom_range(0, 9) != 0) ? nonterms[$urandom_range(0, 1)] : 8'($urandom);
			len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
			send_rule(rules[i], lhs, 4'(len));
		end
		foreach (states[s]) begin
			foreach (terms[t]) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					send_entry(states[s], terms[t], KIND_SHIFT, states[$urandom_range(0, 5)]);
				else if (r < 85)
					send_entry(states[s], terms[t], KIND_REDUCE, 10'(rules[$urandom_range(0, 3)]));
				else if (r < 92)
					send_entry(states[s], terms[t], KIND_NONE, 10'($urandom));
				else if (r < 96)
					send_entry(states[s], terms[t], KIND_UNUSED, 10'($urandom));
				else
					send_entry(states[s], terms[t], KIND_REDUCE,
						10'($urandom_range(DEF_RULE_COUNT, 1023)));
			end
			foreach (nonterms[n]) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					send_entry(states[s], nonterms[n], KIND_SHIFT, states[$urandom_range(0, 5)]);
				else if (r < 92)
					send_entry(states[s], nonterms[n], KIND_NONE, 10'($urandom));
				else
					send_entry(states[s], nonterms[n], KIND_REDUCE,
						10'(rules[$urandom_range(0, 3)]));
			end
		end
		repeat ($urandom_range(4, 8)) begin
			if ($urandom_range(0, 9) != 0)
				send_start();
			len = $urandom_range(1, 16);
			for (int k = 1; k <= len; k++) begin
				if ($urandom_range(0, 19) == 0)
					send_noise();
				sym = ($urandom_range(0, 9) != 0) ? terms[$urandom_range(0, 3)] : 8'($urandom);
				send_token(sym, (k == len) || ($urandom_range(0, 19) == 0));
			end
		end
	endtask

	initial begin
		logic [SYMBOL_W-1:0] deep_sym;
		logic [STATE_W-1:0]  deep_state;
		s_tvalid = 1'b0;
		s_tuser = ACT_START;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		n_entries = 0;
		n_rules = 0;
		n_starts = 0;
		n_tokens = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty table: syntax error, then the latched error ignores tlast
		send_token(8'd0, 1'b0);
		send_token(8'd10, 1'b1);
		send_rule(8'd0, 8'd200, 4'd1);
		send_rule(8'd255, 8'd255, 4'd15);
		send_rule(8'd1, 8'd201, 4'd0);
		send_entry(10'd0, 8'd10, KIND_SHIFT, 10'd5);
		send_entry(10'd5, 8'd11, KIND_REDUCE, 10'd0);
		send_entry(10'd0, 8'd200, KIND_SHIFT, 10'd6);
		send_entry(10'd6, 8'd11, KIND_SHIFT, 10'd1023);
		send_entry(10'd1023, 8'd255, KIND_REDUCE, 10'd255);
		send_entry(10'd1023, 8'd12, KIND_REDUCE, 10'd600);
		send_entry(10'd6, 8'd12, KIND_REDUCE, 10'd0);
		send_entry(10'd0, 8'd12, KIND_SHIFT, 10'd6);
		send_entry(10'd5, 8'd13, KIND_REDUCE, 10'd1);
		send_entry(10'd0, 8'd255, KIND_UNUSED, 10'd5);
		// reduce then goto, accept, then parse on into an underflow of the long rule
		send_start();
		send_token(8'd10, 1'b0);
		send_token(8'd11, 1'b1);
		send_token(8'd255, 1'b0);
		// reduce by a rule number past the rule table
		send_start();
		send_token(8'd10, 1'b0);
		send_token(8'd11, 1'b0);
		send_token(8'd12, 1'b0);
		// reduce whose goto lands on the same state forever
		send_start();
		send_token(8'd12, 1'b0);
		send_token(8'd12, 1'b1);
		// goto that is not a shift
		send_start();
		send_token(8'd10, 1'b0);
		send_token(8'd13, 1'b0);
		// entry loaded with the unused kind reads as none
		send_start();
		send_token(8'd255, 1'b1);
		drain();

		// one state shifting onto itself fills the stack, accept at full depth, then overflow
		idle_on = 1'b0;
		deep_sym = 8'($urandom);
		deep_state = 10'($urandom_range(1, 1023));
		send_entry(10'd0, deep_sym, KIND_SHIFT, deep_state);
		send_entry(deep_state, deep_sym, KIND_SHIFT, deep_state);
		send_start();
		for (int k = 1; k <= DEF_STACK_DEPTH; k++)
			send_token(deep_sym, k == DEF_STACK_DEPTH - 1);
		drain();

		while (n_entries + n_rules + n_starts + n_tokens < 850) begin
			idle_on = ($urandom_range(0, 3) != 0);
			grammar_phase();
			drain();
		end
		idle_on = 1'b0;
		grammar_phase();
		drain();
		repeat (100) @(posedge clk);

		$display("covered %0d table loads, %0d rule loads, %0d starts and %0d tokens",
			n_entries, n_rules, n_starts, n_tokens);
		$display("%0d result transfers compared against the predicted parse", checked);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
hdl/lr1sr_pkg.sv
hdl/lr1sr_ram.sv
hdl/lr1sr_ctrl.sv
hdl/lr1sr_dp.sv
hdl/lr1_shift_reduce_recognizer.sv
tb/sv/lr1_checker.sv
tb/sv/testbench.sv
